FILE: hdl/mit_pkg.sv
// Package for the minimum image translation block: widths, types and register codes.
// No dependencies.
package mit_pkg;
   localparam int MaxAtoms  = 256;
   localparam int AddrW     = $clog2(MaxAtoms);
   localparam int PosW      = 48;
   localparam int NumCells  = 27;

   typedef logic signed [15:0] coord_type;
   typedef logic signed [17:0] trans_type;
   typedef logic signed [18:0] diff_type;
   typedef logic signed [19:0] resid_type;
   typedef logic [41:0]        sqsum_type;
   typedef logic signed [1:0]  shift_type;

   typedef enum logic [1:0] {
      REG_MASK   = 2'd0,
      REG_CELL_A = 2'd1,
      REG_CELL_B = 2'd2,
      REG_CELL_C = 2'd3
   } reg_index_type;

   // Data carried from one cell to the next.
   typedef struct packed {
      logic      vld;
      logic      last;
      diff_type  dx;
      diff_type  dy;
      diff_type  dz;
      sqsum_type best;
      shift_type ba;
      shift_type bb;
      shift_type bc;
   } link_type;

   function automatic coord_type comp(input logic [47:0] v, input int k);
      comp = coord_type'(v[16*k +: 16]);
   endfunction
endpackage

FILE: hdl/mit_ram.sv
// Generic single-port write, single-port registered-read RAM.
// No dependencies.
module mit_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/mit_cell.sv
// One candidate-shift cell: residual, squared length, strict-less compare.
// Depends on mit_pkg.
module mit_cell (
   input  logic              clock,
   input  logic              reset,
   input  mit_pkg::link_type link_in,
   input  mit_pkg::trans_type tx,
   input  mit_pkg::trans_type ty,
   input  mit_pkg::trans_type tz,
   input  mit_pkg::shift_type sa,
   input  mit_pkg::shift_type sb,
   input  mit_pkg::shift_type sc,
   input  logic              en,
   output mit_pkg::link_type link_out
);
   import mit_pkg::*;

   resid_type rx, ry, rz;
   sqsum_type s;
   link_type  link_ff, link_in_w;

   always_comb begin
      rx = resid_type'(link_in.dx) - resid_type'(tx);
      ry = resid_type'(link_in.dy) - resid_type'(ty);
      rz = resid_type'(link_in.dz) - resid_type'(tz);
      s  = sqsum_type'(rx * rx) + sqsum_type'(ry * ry) + sqsum_type'(rz * rz);
      link_in_w = link_in;
      if (en && (s < link_in.best)) begin
         link_in_w.best = s;
         link_in_w.ba   = sa;
         link_in_w.bb   = sb;
         link_in_w.bc   = sc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) link_ff.vld <= 1'b0;
      else       link_ff.vld <= link_in.vld;
      link_ff.last <= link_in_w.last;
      link_ff.dx   <= link_in_w.dx;
      link_ff.dy   <= link_in_w.dy;
      link_ff.dz   <= link_in_w.dz;
      link_ff.best <= link_in_w.best;
      link_ff.ba   <= link_in_w.ba;
      link_ff.bb   <= link_in_w.bb;
      link_ff.bc   <= link_in_w.bc;
   end

   assign link_out = link_ff;
endmodule

FILE: hdl/minimum_image_translation.sv
// Top level of the minimum image translation block: position store, cell chain.
// Depends on mit_pkg, mit_ram and mit_cell.
//
// Usage:
//  - Requests enter on start when busy is low. cmd 0 stores a Q8.8 position
//    for atom req_atom_first; cmd 1 queries the pair (first, second).
//  - A store is written at the accepting edge and gives no response.
//  - A query reads both positions in turn from the single-read
//    position RAM, forms the difference, then sends it down a chain of 27
//    cells, one per candidate shift (a outermost, c innermost, -1..+1).
//    Each cell holds one pipeline stage and hands its best-so-far to the
//    next every cycle. Non-periodic shifts are masked off in their cells.
//  - The response appears on rsp_* with rsp_valid for one cycle, after the
//    read states, the head stage, the chain and the output register. busy
//    stays high for the whole query, so one query runs at a time; the block
//    takes no new request until the query has left the chain.
//  - The receiver cannot stall; responses are never held.
//  - csr_* writes registers (0 mask, 1..3 cell vectors) and is always ready.
//    Write only while idle.
//  - Reset (synchronous, active high) clears configuration and control state.
//    The position store is not cleared; read only written atoms.
module minimum_image_translation (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [7:0]          req_atom_first,
   input  logic [7:0]          req_atom_second,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic signed [15:0]  req_pos_z,
   output logic                rsp_valid,
   output logic signed [1:0]   rsp_shift_a,
   output logic signed [1:0]   rsp_shift_b,
   output logic signed [1:0]   rsp_shift_c,
   output logic signed [17:0]  rsp_trans_x,
   output logic signed [17:0]  rsp_trans_y,
   output logic signed [17:0]  rsp_trans_z,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [47:0]         csr_data
);
   import mit_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_RD1   = 5'b00010,
      S_RD2   = 5'b00100,
      S_CHAIN = 5'b01000,
      S_WR    = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [2:0]   mask_ff;
   logic [47:0]  cella_ff, cellb_ff, cellc_ff;
   logic [AddrW-1:0] first_ff, second_ff, rd_addr;
   logic [PosW-1:0]  pi_ff, rd_data;
   logic         wr_en;
   link_type     link_head;
   link_type     links [NumCells+1];

   // configuration: always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         cella_ff <= '0;
         cellb_ff <= '0;
         cellc_ff <= '0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_MASK:   mask_ff  <= csr_data[2:0];
            REG_CELL_A: cella_ff <= csr_data;
            REG_CELL_B: cellb_ff <= csr_data;
            REG_CELL_C: cellc_ff <= csr_data;
            default:    mask_ff  <= mask_ff;
         endcase
      end
   end

   assign busy  = (state_ff != S_IDLE);
   assign wr_en = start && !busy && !req_cmd;
   assign rd_addr = (state_ff == S_IDLE) ? req_atom_first : second_ff;

   mit_ram #(.Width(PosW), .Depth(MaxAtoms)) u_pos_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_atom_first[AddrW-1:0]),
      .wr_data({req_pos_z, req_pos_y, req_pos_x}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // sequencer: hold busy until the query leaves the chain
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = req_cmd ? S_RD1 : S_WR;
         S_WR:    state_in = S_IDLE;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_CHAIN;
         S_CHAIN: if (links[NumCells].vld) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
      if (state_ff == S_IDLE && start) begin
         first_ff  <= req_atom_first;
         second_ff <= req_atom_second;
      end
      if (state_ff == S_RD1) pi_ff <= rd_data;
   end

   // head of chain: difference and the unshifted squared length
   diff_type hdx, hdy, hdz;
   always_comb begin
      hdx = diff_type'(comp(pi_ff, 0)) - diff_type'(comp(rd_data, 0));
      hdy = diff_type'(comp(pi_ff, 1)) - diff_type'(comp(rd_data, 1));
      hdz = diff_type'(comp(pi_ff, 2)) - diff_type'(comp(rd_data, 2));
      link_head.vld  = (state_ff == S_RD2);
      link_head.last = 1'b1;
      link_head.dx   = hdx;
      link_head.dy   = hdy;
      link_head.dz   = hdz;
      link_head.best = sqsum_type'(hdx * hdx) + sqsum_type'(hdy * hdy)
                     + sqsum_type'(hdz * hdz);
      link_head.ba   = '0;
      link_head.bb   = '0;
      link_head.bc   = '0;
   end

   // hold the head one stage so the squares are registered
   always_ff @(posedge clock) begin
      if (reset) links[0].vld <= 1'b0;
      else       links[0].vld <= link_head.vld;
      links[0].last <= link_head.last;
      links[0].dx   <= link_head.dx;
      links[0].dy   <= link_head.dy;
      links[0].dz   <= link_head.dz;
      links[0].best <= link_head.best;
      links[0].ba   <= link_head.ba;
      links[0].bb   <= link_head.bb;
      links[0].bc   <= link_head.bc;
   end

   // translation for a given shift triple
   function automatic trans_type tcomp(input shift_type a, input shift_type b,
                                       input shift_type c, input logic [47:0] va,
                                       input logic [47:0] vb, input logic [47:0] vc,
                                       input int k);
      tcomp = trans_type'(a) * trans_type'(comp(va, k))
            + trans_type'(b) * trans_type'(comp(vb, k))
            + trans_type'(c) * trans_type'(comp(vc, k));
   endfunction

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      localparam shift_type Sa = shift_type'(g / 9 - 1);
      localparam shift_type Sb = shift_type'((g / 3) % 3 - 1);
      localparam shift_type Sc = shift_type'(g % 3 - 1);
      logic en;
      assign en = (mask_ff[0] || Sa == 2'sd0) && (mask_ff[1] || Sb == 2'sd0)
               && (mask_ff[2] || Sc == 2'sd0);
      mit_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .link_in (links[g]),
         .tx      (tcomp(Sa, Sb, Sc, cella_ff, cellb_ff, cellc_ff, 0)),
         .ty      (tcomp(Sa, Sb, Sc, cella_ff, cellb_ff, cellc_ff, 1)),
         .tz      (tcomp(Sa, Sb, Sc, cella_ff, cellb_ff, cellc_ff, 2)),
         .sa      (Sa),
         .sb      (Sb),
         .sc      (Sc),
         .en      (en),
         .link_out(links[g+1])
      );
   end

   // output register: translation of the winning shift
   logic rsp_valid_ff;
   shift_type ra_ff, rb_ff, rc_ff;
   trans_type tx_ff, ty_ff, tz_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= links[NumCells].vld && links[NumCells].last;
      ra_ff <= links[NumCells].ba;
      rb_ff <= links[NumCells].bb;
      rc_ff <= links[NumCells].bc;
      tx_ff <= tcomp(links[NumCells].ba, links[NumCells].bb, links[NumCells].bc,
                     cella_ff, cellb_ff, cellc_ff, 0);
      ty_ff <= tcomp(links[NumCells].ba, links[NumCells].bb, links[NumCells].bc,
                     cella_ff, cellb_ff, cellc_ff, 1);
      tz_ff <= tcomp(links[NumCells].ba, links[NumCells].bb, links[NumCells].bc,
                     cella_ff, cellb_ff, cellc_ff, 2);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_shift_a = ra_ff;
   assign rsp_shift_b = rb_ff;
   assign rsp_shift_c = rc_ff;
   assign rsp_trans_x = tx_ff;
   assign rsp_trans_y = ty_ff;
   assign rsp_trans_z = tz_ff;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without busy query");
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_chain_done: assert property (@(posedge clock) disable iff (reset)
      links[NumCells].vld |=> state_ff == S_IDLE) else $error("chain end missed");
   a_no_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mask_ff == 3'b000 |-> rsp_shift_a == 2'sd0
         && rsp_shift_b == 2'sd0 && rsp_shift_c == 2'sd0)
      else $error("shift on non-periodic cell");
endmodule

FILE: tb/sv/tb_minimum_image_translation.sv
// Testbench for minimum_image_translation: directed and random store/query requests,
// checked against an in-bench minimum image predictor. Depends on mit_pkg and the RTL.
module tb_minimum_image_translation;
   timeunit 1ns;
   timeprecision 1ps;
   import mit_pkg::*;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
   localparam int   DRAIN_CYCLES = 40;
   localparam int   WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic signed [1:0]  sa;
      logic signed [1:0]  sb;
      logic signed [1:0]  sc;
      logic signed [17:0] tx;
      logic signed [17:0] ty;
      logic signed [17:0] tz;
   } image_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = 1'b0;
   logic [7:0]  req_atom_first = '0;
   logic [7:0]  req_atom_second = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic signed [15:0] req_pos_z = '0;
   logic        rsp_valid;
   logic signed [1:0]  rsp_shift_a, rsp_shift_b, rsp_shift_c;
   logic signed [17:0] rsp_trans_x, rsp_trans_y, rsp_trans_z;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   // Shadow of the block's registers and position store.
   logic [2:0]  sh_mask;
   logic [47:0] sh_cell [3];
   logic [47:0] sh_pos [256];
   bit          sh_written [256];

   image_type   pending_images[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          accepted_now;

   minimum_image_translation uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Compute the expected image for a query from the shadow state.
   function automatic image_type predict_image(input logic [7:0] fi, input logic [7:0] se);
      longint d[3], ta[3], tb[3], tc[3], best, s, r;
      int ba, bb, bc, lo[3];
      image_type img;
      ba = 0; bb = 0; bc = 0;
      for (int k = 0; k < 3; k++) begin
         d[k] = longint'($signed(sh_pos[fi][16*k +: 16])) -
                longint'($signed(sh_pos[se][16*k +: 16]));
         ta[k] = longint'($signed(sh_cell[0][16*k +: 16]));
         tb[k] = longint'($signed(sh_cell[1][16*k +: 16]));
         tc[k] = longint'($signed(sh_cell[2][16*k +: 16]));
         lo[k] = sh_mask[k] ? -1 : 0;
      end
      best = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      for (int na = lo[0]; na <= -lo[0]; na++)
         for (int nb = lo[1]; nb <= -lo[1]; nb++)
            for (int nc = lo[2]; nc <= -lo[2]; nc++) begin
               s = 0;
               for (int k = 0; k < 3; k++) begin
                  r = d[k] - na*ta[k] - nb*tb[k] - nc*tc[k];
                  s += r*r;
               end
               if (s < best) begin
                  best = s; ba = na; bb = nb; bc = nc;
               end
            end
      img.sa = ba[1:0]; img.sb = bb[1:0]; img.sc = bc[1:0];
      img.tx = 18'(ba*ta[0] + bb*tb[0] + bc*tc[0]);
      img.ty = 18'(ba*ta[1] + bb*tb[1] + bc*tc[1]);
      img.tz = 18'(ba*ta[2] + bb*tb[2] + bc*tc[2]);
      return img;
   endfunction

   // Send one request after a random gap; record the expected image for a query.
   // start stays high on return; whoever pauses next drops it.
   task automatic send_request(input logic cmd, input logic [7:0] fi, input logic [7:0] se,
                               input logic [15:0] px, input logic [15:0] py,
                               input logic [15:0] pz, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_atom_first <= fi;
      req_atom_second <= se;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      @(posedge clock);
      while (busy) @(posedge clock);
      // Accepted at this edge: update shadow.
      if (cmd == CMD_STORE) begin
         sh_pos[fi] = {pz, py, px};
         sh_written[fi] = 1;
      end else begin
         pending_images.insert(pending_images.size(), predict_image(fi, se));
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      while (pending_images.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MASK: sh_mask = val[2:0];
         REG_CELL_A: sh_cell[0] = val;
         REG_CELL_B: sh_cell[1] = val;
         default: sh_cell[2] = val;
      endcase
   endtask

   task automatic set_lattice(input logic [2:0] m, input logic [47:0] a,
                              input logic [47:0] b, input logic [47:0] c);
      drain_responses();
      write_csr(REG_MASK, {45'd0, m});
      write_csr(REG_CELL_A, a);
      write_csr(REG_CELL_B, b);
      write_csr(REG_CELL_C, c);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_written();
      logic [7:0] i;
      do i = 8'($urandom_range(0, 255)); while (!sh_written[i]);
      return i;
   endfunction

   // Coordinate: mostly small (-2048..2047), sometimes an extreme or any 16-bit value.
   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($signed($urandom_range(0, 4095)) - 2048);
      endcase
   endfunction

   function automatic logic [47:0] rand_cell();
      if ($urandom_range(0, 4) == 0)
         return {16'($urandom_range(0, 65535)), $urandom()};
      return {16'($signed($urandom_range(0, 1023)) - 512),
              16'($signed($urandom_range(0, 1023)) - 512),
              16'($signed($urandom_range(0, 1023)) - 512)};
   endfunction

   // Extremes of positions, ties, no periodic axis, out-of-range translations.
   task automatic test_directed();
      send_request(CMD_STORE, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000);
      send_request(CMD_STORE, 8'd255, 8'hff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_request(CMD_STORE, 8'd1, 8'd0, 16'h8000, 16'h8000, 16'h8000);
      send_request(CMD_STORE, 8'd2, 8'd0, 16'h0080, 16'h0000, 16'h0000);
      // No periodic axis: result must be all zero.
      send_request(CMD_QUERY, 8'd255, 8'd1, '0, '0, '0);
      send_request(CMD_QUERY, 8'd0, 8'd0, 16'hffff, 16'hffff, 16'hffff);
      // Cell vectors at the negative extreme: translation can reach +98304 per axis.
      set_lattice(3'b111, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
      send_request(CMD_QUERY, 8'd255, 8'd1, '0, '0, '0);
      send_request(CMD_QUERY, 8'd1, 8'd255, '0, '0, '0);
      send_request(CMD_QUERY, 8'd0, 8'd0, '0, '0, '0);
      // Exact tie at half a cell: unshifted image must win.
      set_lattice(3'b001, 48'h0000_0000_0100, 48'h7fff_7fff_7fff, 48'h0);
      send_request(CMD_QUERY, 8'd2, 8'd0, '0, '0, '0);
      send_request(CMD_QUERY, 8'd0, 8'd2, '0, '0, '0);
      set_lattice(3'b110, 48'h0, 48'h0000_0100_0000, 48'h0100_0000_0000);
      send_request(CMD_QUERY, 8'd255, 8'd0, '0, '0, '0);
      send_request(CMD_QUERY, 8'd1, 8'd0, '0, '0, '0);
      set_lattice(3'b111, 48'h7fff_7fff_7fff, 48'h8000_0000_7fff, 48'h0000_8000_0001);
      send_request(CMD_QUERY, 8'd255, 8'd1, '0, '0, '0);
      send_request(CMD_QUERY, 8'd1, 8'd2, '0, '0, '0);
   endtask

   // Random phases, random lattices (last non-periodic); stores and queries mixed.
   task automatic test_random();
      for (int phase = 0; phase < 8; phase++) begin
         set_lattice(phase == 7 ? 3'b000 : 3'($urandom_range(0, 7)),
                     rand_cell(), rand_cell(), rand_cell());
         for (int n = 0; n < 240; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_request(CMD_STORE, 8'($urandom_range(0, 255)), 8'($urandom()),
                            rand_coord(), rand_coord(), rand_coord(),
                            $urandom_range(0, 9) == 0);
            else
               send_request(CMD_QUERY, pick_written(), pick_written(),
                            16'($urandom()), 16'($urandom()), 16'($urandom()),
                            $urandom_range(0, 9) == 0);
            // Hold off once until every outstanding response has arrived.
            if (n == 120 && phase == 2) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_images.size() != 0) @(posedge clock);
            end
         end
      end
   endtask

   // Check each response against the oldest expectation.
   always @(posedge clock) begin
      image_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_shift_a, rsp_shift_b, rsp_shift_c,
                 rsp_trans_x, rsp_trans_y, rsp_trans_z};
         if (pending_images.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = pending_images.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // Watchdog: count cycles with no request, response or write accepted.
   always @(posedge clock) begin
      accepted_now = (start && !busy) || rsp_valid || (csr_valid && csr_ready);
      if (reset || accepted_now) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("minimum_image_translation verification failed");
         $finish;
      end
   end

   initial begin
      sh_mask = '0;
      for (int i = 0; i < 3; i++) sh_cell[i] = '0;
      for (int i = 0; i < 256; i++) begin
         sh_pos[i] = '0;
         sh_written[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      drain_responses();
      if (mismatches == 0 && pending_images.size() == 0)
         $display("minimum_image_translation verification clean");
      else
         $display("minimum_image_translation verification failed");
      $finish;
   end
endmodule
